### sv/vthp_pkg.sv
package vthp_pkg;

  localparam int unsigned SampleBits    = 16;
  localparam int unsigned FracBits      = 16;
  localparam int unsigned ColorBits     = 8;
  // position runs 0..4.0, so two integer bits plus one for the exact top value
  localparam int unsigned QuotBits      = FracBits + 3;
  localparam int unsigned SectorBits    = QuotBits - FracBits;
  localparam int unsigned StepsPerStage = 3;
  // the front stage yields the top quotient bit, the divider stages the rest
  localparam int unsigned DivStages     = (QuotBits - 1 + StepsPerStage - 1) / StepsPerStage;
  localparam int unsigned LeftBits      = $clog2(QuotBits);
  localparam int unsigned CfgIdxBits    = 2;

  localparam logic [CfgIdxBits-1:0] REG_LOW_BOUND  = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] REG_HIGH_BOUND = CfgIdxBits'(1);

  localparam logic [SampleBits-1:0] LowBoundReset  = SampleBits'(745);
  localparam logic [SampleBits-1:0] HighBoundReset = SampleBits'(808);

  localparam logic [SectorBits-1:0] SEC_RED_YELLOW  = SectorBits'(0);
  localparam logic [SectorBits-1:0] SEC_YELLOW_GRN  = SectorBits'(1);
  localparam logic [SectorBits-1:0] SEC_GRN_CYAN    = SectorBits'(2);
  localparam logic [SectorBits-1:0] SEC_CYAN_BLUE   = SectorBits'(3);

  localparam logic [ColorBits-1:0] ColorFull = '1;
  localparam logic [ColorBits-1:0] ColorNone = '0;

  typedef logic [SampleBits-1:0] sample_t;
  typedef logic [ColorBits-1:0]  color_t;

  typedef enum logic [1:0] {
    CLS_RED  = 2'd0,
    CLS_BLUE = 2'd1,
    CLS_RAMP = 2'd2
  } cls_e;

  // beat carried through the divider stages
  typedef struct packed {
    cls_e                  cls;
    sample_t               span;
    sample_t               rem;
    logic [QuotBits-1:0]   quot;
    logic [LeftBits-1:0]   left;
  } div_t;

endpackage

### sv/vthp_front.sv
module vthp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  vthp_pkg::sample_t sample_i,
  input  vthp_pkg::sample_t low_bound_i,
  input  vthp_pkg::sample_t high_bound_i,
  output logic              valid_o,
  output vthp_pkg::div_t    data_o
);
  import vthp_pkg::*;

  logic    valid_q;
  div_t    data_d, data_q;
  sample_t offset, span;
  logic    top_bit;

  assign offset  = sample_i - low_bound_i;
  assign span    = high_bound_i - low_bound_i;
  // offset never exceeds span on the ramp, so the top bit is set only at equality
  assign top_bit = (offset == span);

  always_comb begin
    data_d.span = span;
    data_d.rem  = top_bit ? '0 : offset;
    data_d.quot = QuotBits'(top_bit);
    data_d.left = LeftBits'(QuotBits - 1);
    if (sample_i < low_bound_i) begin
      data_d.cls = CLS_RED;
    end else if (sample_i > high_bound_i) begin
      data_d.cls = CLS_BLUE;
    end else if (span == '0) begin
      data_d.cls = CLS_RED;
    end else begin
      data_d.cls = CLS_RAMP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### sv/vthp_div_stage.sv
module vthp_div_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  vthp_pkg::div_t data_i,
  output logic           valid_o,
  output vthp_pkg::div_t data_o
);
  import vthp_pkg::*;

  logic                  valid_q;
  div_t                  data_d, data_q;
  logic [SampleBits:0]   trial;
  logic [SampleBits:0]   diff;
  logic                  qbit;

  // restoring division, a few quotient bits per stage
  always_comb begin
    data_d = data_i;
    trial  = '0;
    diff   = '0;
    qbit   = 1'b0;
    for (int k = 0; k < StepsPerStage; k++) begin
      if (data_d.left != '0) begin
        trial = {data_d.rem, 1'b0};
        diff  = trial - {1'b0, data_d.span};
        qbit  = (trial >= {1'b0, data_d.span});
        data_d.rem  = qbit ? diff[SampleBits-1:0] : trial[SampleBits-1:0];
        data_d.quot = {data_d.quot[QuotBits-2:0], qbit};
        data_d.left = data_d.left - LeftBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### sv/vthp_color.sv
module vthp_color (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  vthp_pkg::div_t   data_i,
  output logic             valid_o,
  output vthp_pkg::color_t red_o,
  output vthp_pkg::color_t green_o,
  output vthp_pkg::color_t blue_o
);
  import vthp_pkg::*;

  logic                    valid_q;
  color_t                  red_d, green_d, blue_d;
  color_t                  red_q, green_q, blue_q;
  logic [SectorBits-1:0]   sector;
  logic [FracBits:0]       frac;
  logic [FracBits:0]       frac_inv;
  logic [FracBits+8:0]     up_prod, dn_prod;
  color_t                  up, dn;

  assign sector   = data_i.quot[QuotBits-1:FracBits];
  assign frac     = {1'b0, data_i.quot[FracBits-1:0]};
  assign frac_inv = {1'b1, {FracBits{1'b0}}} - frac;

  // times 255 as shift and subtract
  assign up_prod = {frac, 8'b0} - {8'b0, frac};
  assign dn_prod = {frac_inv, 8'b0} - {8'b0, frac_inv};
  assign up      = up_prod[FracBits+7:FracBits];
  assign dn      = dn_prod[FracBits+7:FracBits];

  always_comb begin
    red_d   = ColorFull;
    green_d = ColorNone;
    blue_d  = ColorNone;
    case (data_i.cls)
      CLS_BLUE: begin
        red_d  = ColorNone;
        blue_d = ColorFull;
      end
      CLS_RAMP: begin
        case (sector)
          SEC_RED_YELLOW: begin
            red_d   = ColorFull;
            green_d = up;
            blue_d  = ColorNone;
          end
          SEC_YELLOW_GRN: begin
            red_d   = dn;
            green_d = ColorFull;
            blue_d  = ColorNone;
          end
          SEC_GRN_CYAN: begin
            red_d   = ColorNone;
            green_d = ColorFull;
            blue_d  = up;
          end
          SEC_CYAN_BLUE: begin
            red_d   = ColorNone;
            green_d = dn;
            blue_d  = ColorFull;
          end
          default: begin
            red_d   = up;
            green_d = ColorNone;
            blue_d  = ColorFull;
          end
        endcase
      end
      default: begin
        red_d   = ColorFull;
        green_d = ColorNone;
        blue_d  = ColorNone;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign valid_o = valid_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

### sv/value_to_hue_pseudocolor_unit.sv
// channel | signals                                   | dir | flow
// in      | in_valid_i, in_stall_o, sample_i          | in  | one sample per beat
// out     | out_valid_o, out_stall_i, red/green/blue_o | out | one rgb pixel per beat
// cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i,    | in  | register write, always ready
//         | cfg_data_i                                |     |
//
// one beat enters per cycle while in_stall_o is low, registered at every stage
// the depth is set by the restoring divider, three quotient bits per stage
// reset clears the valid bits and loads the bound registers, no clearing pass
// each stage holds only while its successor is full and stalled, so bubbles
// close up and in_stall_o rises only when every stage holds a beat
module value_to_hue_pseudocolor_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  vthp_pkg::sample_t                   sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output vthp_pkg::color_t                    red_o,
  output vthp_pkg::color_t                    green_o,
  output vthp_pkg::color_t                    blue_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [vthp_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  vthp_pkg::sample_t                   cfg_data_i
);
  import vthp_pkg::*;

  localparam int unsigned NumStages = DivStages + 2;

  sample_t                 low_bound_q, high_bound_q;
  logic [NumStages-1:0]    stage_en;
  logic [NumStages-1:0]    stage_vld;
  div_t                    div_bus [DivStages+1];

  // bound registers, unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_bound_q  <= LowBoundReset;
      high_bound_q <= HighBoundReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_LOW_BOUND:  low_bound_q  <= cfg_data_i;
        REG_HIGH_BOUND: high_bound_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // enable chain: a stage loads when empty or when the next one loads
  assign stage_en[NumStages-1] = !stage_vld[NumStages-1] || !out_stall_i;
  for (genvar g = 0; g < NumStages - 1; g++) begin : g_en
    assign stage_en[g] = !stage_vld[g] || stage_en[g+1];
  end

  assign in_stall_o = !stage_en[0];

  // classify, take distance and span, resolve the top quotient bit
  vthp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (stage_en[0]),
    .valid_i      (in_valid_i),
    .sample_i     (sample_i),
    .low_bound_i  (low_bound_q),
    .high_bound_i (high_bound_q),
    .valid_o      (stage_vld[0]),
    .data_o       (div_bus[0])
  );

  // divider pipeline producing the fixed-point hue position
  for (genvar g = 0; g < DivStages; g++) begin : g_div
    vthp_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (stage_en[g+1]),
      .valid_i (stage_vld[g]),
      .data_i  (div_bus[g]),
      .valid_o (stage_vld[g+1]),
      .data_o  (div_bus[g+1])
    );
  end

  // sector lookup and ramp, doubles as the output register
  vthp_color u_color (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (stage_en[NumStages-1]),
    .valid_i (stage_vld[NumStages-2]),
    .data_i  (div_bus[DivStages]),
    .valid_o (stage_vld[NumStages-1]),
    .red_o   (red_o),
    .green_o (green_o),
    .blue_o  (blue_o)
  );

  assign out_valid_o = stage_vld[NumStages-1];

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

// testbench for the value to hue pseudocolour unit
// - driver pulls samples from a queue that the sequencer fills, one beat per handshake
// - every accepted sample is run through a local predictor and the pixel is queued
// - monitor takes output beats and compares them channel by channel with the oldest pixel
// - bound registers are rewritten only while the pipeline is empty
module tb;
  import vthp_pkg::*;

  localparam int unsigned ClockHalf   = 5;
  localparam int unsigned ResetCycles = 11;
  // pipeline depth is DivStages + 2, the drain wait is longer than that
  localparam int unsigned DrainCycles = DivStages + 10;
  // longest quiet spell of a correct run comes from the long hold, the limit lies above it
  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned LongHold    = 64;
  localparam int unsigned RandomItems = 250;
  localparam int unsigned RandomPhases = 8;

  // indexes outside the register map, writes there must change nothing
  localparam logic [CfgIdxBits-1:0] REG_SPARE_2 = CfgIdxBits'(2);
  localparam logic [CfgIdxBits-1:0] REG_SPARE_3 = CfgIdxBits'(3);

  typedef struct packed {
    color_t red;
    color_t green;
    color_t blue;
  } pixel_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // input channel
  logic    in_valid  = 1'b0;
  logic    in_stall_o;
  sample_t in_sample = '0;

  // output channel
  logic   out_valid_o;
  logic   out_stall = 1'b0;
  color_t red_o, green_o, blue_o;

  // register write channel
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxBits-1:0] cfg_index = '0;
  sample_t               cfg_data  = '0;

  // local copy of the bound registers, tracks every completed write
  sample_t low_copy  = LowBoundReset;
  sample_t high_copy = HighBoundReset;

  sample_t samples_waiting[$];
  pixel_t  pixels_due[$];

  int unsigned mismatches = 0;
  int unsigned cycles_without_beat = 0;

  // idling switch for both sides, and the one long receiver hold
  logic idle_on       = 1'b0;
  logic long_hold_arm = 1'b0;
  logic long_hold_taken = 1'b0;

  int unsigned send_gap = 0;
  int unsigned hold_left = 0;

  value_to_hue_pseudocolor_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .sample_i    (in_sample),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #(ClockHalf) clk_i = ~clk_i;
  end

  // expected pixel for one sample under the given bounds
  function automatic pixel_t pseudocolor_of(sample_t s, sample_t lo, sample_t hi);
    longint unsigned span, offs, pos, frac, up, dn;
    logic [SectorBits-1:0] sector;
    pixel_t px;
    // below range first, then above, then an empty span all give a pure colour
    if (s < lo) return '{ColorFull, ColorNone, ColorNone};
    if (s > hi) return '{ColorNone, ColorNone, ColorFull};
    span = 64'(hi) - 64'(lo);
    if (span == 0) return '{ColorFull, ColorNone, ColorNone};
    offs   = 64'(s) - 64'(lo);
    // position 0..4.0 with FracBits fraction bits, truncated
    pos    = (offs << (FracBits + 2)) / span;
    frac   = pos & ((64'd1 << FracBits) - 1);
    up     = (frac * 255) >> FracBits;
    dn     = (((64'd1 << FracBits) - frac) * 255) >> FracBits;
    sector = SectorBits'(pos >> FracBits);
    case (sector)
      SEC_RED_YELLOW: px = '{ColorFull, color_t'(up), ColorNone};
      SEC_YELLOW_GRN: px = '{color_t'(dn), ColorFull, ColorNone};
      SEC_GRN_CYAN:   px = '{ColorNone, ColorFull, color_t'(up)};
      SEC_CYAN_BLUE:  px = '{ColorNone, color_t'(dn), ColorFull};
      // only the exact top of the range lands here
      default:        px = '{color_t'(up), ColorNone, ColorFull};
    endcase
    return px;
  endfunction

  // driver: the predictor runs on the accepted beat, then the next sample is chosen
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_sample <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall_o) begin
        pixels_due.push_back(pseudocolor_of(in_sample, low_copy, high_copy));
      end
      // a beat on offer stays put until it is taken
      if (!in_valid || !in_stall_o) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (idle_on && samples_waiting.size() != 0 && $urandom_range(0, 5) == 0) begin
          // random pause with no beat on offer
          send_gap <= $urandom_range(0, 7);
          in_valid <= 1'b0;
        end else if (samples_waiting.size() != 0) begin
          in_valid <= 1'b1;
          in_sample <= samples_waiting.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_channel(string name, color_t want, color_t got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // monitor: compares output beats and drives the stall, bursts plus one long hold
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pixel_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      long_hold_taken <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (pixels_due.size() == 0) begin
          mismatches++;
          $display("%0t: pixel beat with none expected, got %0d/%0d/%0d",
                   $time, red_o, green_o, blue_o);
        end else begin
          want = pixels_due.pop_front();
          check_channel("red", want.red, red_o);
          check_channel("green", want.green, green_o);
          check_channel("blue", want.blue, blue_o);
        end
      end
      if (long_hold_arm && !long_hold_taken) begin
        // sender keeps offering while this runs, so the pipe fills and backs up
        long_hold_taken <= 1'b1;
        hold_left <= LongHold;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= (hold_left != 1);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        hold_left <= $urandom_range(1, 8);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: ends the run if no channel moves a beat for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
        (cfg_valid && cfg_ready_o)) begin
      cycles_without_beat <= 0;
    end else if (cycles_without_beat >= StallLimit) begin
      $display("value_to_hue_pseudocolor_unit: mismatch");
      $finish;
    end else begin
      cycles_without_beat <= cycles_without_beat + 1;
    end
  end

  // one register write, the local copy follows on the handshake
  task automatic write_reg(logic [CfgIdxBits-1:0] idx, sample_t value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LOW_BOUND:  low_copy = value;
      REG_HIGH_BOUND: high_copy = value;
      default: ;
    endcase
  endtask

  task automatic set_bounds(int lo, int hi);
    write_reg(REG_LOW_BOUND, sample_t'(lo));
    write_reg(REG_HIGH_BOUND, sample_t'(hi));
  endtask

  // wait until every sample went in and every pixel came out, then let the pipe settle
  task automatic drain();
    @(negedge clk_i);
    while (samples_waiting.size() != 0 || in_valid || pixels_due.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic queue_samples(int list[]);
    @(negedge clk_i);
    foreach (list[i]) samples_waiting.push_back(sample_t'(list[i]));
    drain();
  endtask

  // mostly inside the current range, some near each bound, some anywhere
  function automatic sample_t draw_sample();
    int a, b, v;
    a = (low_copy < high_copy) ? int'(low_copy) : int'(high_copy);
    b = (low_copy < high_copy) ? int'(high_copy) : int'(low_copy);
    case ($urandom_range(0, 9))
      0: v = $urandom_range(0, 65535);
      1: v = int'(low_copy) + int'($urandom_range(0, 6)) - 3;
      2: v = int'(high_copy) + int'($urandom_range(0, 6)) - 3;
      default: v = $urandom_range(a, b);
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return sample_t'(v);
  endfunction

  // sequencer
  initial begin
    int lo, hi;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset bounds: both sides of the low bound, just above the high bound, both ends of the ramp and its middle
    queue_samples('{744, 745, 746, 777, 808, 809});
    // full range: sector starts and the two extremes of the field
    set_bounds(0, 65535);
    queue_samples('{0, 16384, 32768, 49152, 65535});
    // equal bounds give red at the bound itself
    set_bounds(1000, 1000);
    queue_samples('{999, 1000, 1001});
    // inverted bounds, and writes to spare indexes that must not land
    set_bounds(5000, 100);
    write_reg(REG_SPARE_2, sample_t'($urandom_range(0, 65535)));
    write_reg(REG_SPARE_3, sample_t'($urandom_range(0, 65535)));
    queue_samples('{99, 100, 101, 5000, 5001});

    for (int ph = 0; ph < RandomPhases; ph++) begin
      case (ph)
        0: begin lo = 0; hi = 65535; end
        1: begin
          lo = $urandom_range(0, 60000);
          hi = lo + int'($urandom_range(1, 300));
        end
        2: begin lo = $urandom_range(0, 65535); hi = lo; end
        3: begin lo = $urandom_range(0, 65535); hi = $urandom_range(0, 65535); end
        4: begin lo = 0; hi = $urandom_range(1, 4); end
        5: begin lo = 65534; hi = 65535; end
        6: begin
          lo = $urandom_range(0, 65535);
          hi = lo + int'($urandom_range(1, 2000));
        end
        default: begin lo = int'(LowBoundReset); hi = int'(HighBoundReset); end
      endcase
      if (hi > 65535) hi = 65535;
      set_bounds(lo, hi);
      if (ph == 3) write_reg(REG_SPARE_3, sample_t'($urandom_range(0, 65535)));
      // long hold with a steady sender in one phase, no idling at the end
      idle_on = !(ph == 1 || ph == RandomPhases - 1);
      long_hold_arm = (ph == 1);
      @(negedge clk_i);
      for (int n = 0; n < RandomItems; n++) samples_waiting.push_back(draw_sample());
      drain();
    end

    if (mismatches == 0 && pixels_due.size() == 0) begin
      $display("value_to_hue_pseudocolor_unit: match");
    end else begin
      $display("value_to_hue_pseudocolor_unit: mismatch");
    end
    $finish;
  end

endmodule
